@@ rtl/core/fps_pkg.sv @@
// Package for the frame peak suppression block: sizes, payload types and control structs.
`default_nettype none

package fps_pkg;

  localparam int unsigned MAX_PIXELS  = 256;
  localparam int unsigned MAX_PEAKS   = 64;
  localparam int unsigned COORD_BITS  = 9;
  localparam int unsigned BRIGHT_BITS = 16;
  localparam int unsigned FRAME_BITS  = 32;

  localparam int unsigned PIX_AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned PIX_CW  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned PEAK_AW = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
  localparam int unsigned PEAK_CW = $clog2(MAX_PEAKS + 1);

  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = (BRIGHT_BITS > COORD_BITS) ? BRIGHT_BITS : COORD_BITS;

  localparam logic [CFG_IDX_BITS-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_X  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_Y  = 2'd2;

  localparam logic [BRIGHT_BITS-1:0] THRESHOLD_RESET = BRIGHT_BITS'(100);
  localparam logic [COORD_BITS-1:0]  WINDOW_RESET    = COORD_BITS'(5);

  typedef struct packed {
    logic [FRAME_BITS-1:0]  frame_number;
    logic [COORD_BITS-1:0]  pixel_x;
    logic [COORD_BITS-1:0]  pixel_y;
    logic [BRIGHT_BITS-1:0] pixel_brightness;
    logic                   end_of_frame;
  } pixel_t;

  typedef struct packed {
    logic [FRAME_BITS-1:0]  peak_frame;
    logic [COORD_BITS-1:0]  peak_x;
    logic [COORD_BITS-1:0]  peak_y;
    logic [BRIGHT_BITS-1:0] peak_brightness;
    logic                   last_peak;
    logic                   frame_truncated;
  } peak_t;

  // One stored pixel or peak
  typedef struct packed {
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [BRIGHT_BITS-1:0] bright;
  } entry_t;

  // Commands from the controller
  typedef struct packed {
    logic               load;        // transfer a pixel into the store
    logic               pass_start;  // begin a scan of the store
    logic               suppress;    // the starting pass clears around the last best
    logic               clear_frame; // drop the stored frame
    logic               push;        // save the best pixel as a peak
    logic               buf_rd;      // read a saved peak
    logic               out_load;    // move the read peak into the output register
    logic               last;
    logic               truncated;
    logic [PEAK_AW-1:0] buf_idx;
  } cmd_t;

  // Status from the datapath
  typedef struct packed {
    logic pass_done;
    logic qualify;
    logic overflow;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/core/frame_peak_suppression.sv @@
// Top level of the frame peak suppression block: config registers and unit hookup.
// Load: one pixel transfer per cycle until the end_of_frame pixel; input then stalls.
// Search: each pass reads all N stored pixels through one store read port, then a decision
//   state follows, and a frame with P peaks takes P + 1 passes (at most MAX_PEAKS + 1).
// Output: read, load, then wait out any output stall per peak; input resumes after the last one.
// Reset clears the frame state, the counters and the output valid, and restores the
//   registers to threshold 100 and windows 5; the pixel store is not cleared.
`default_nettype none

module frame_peak_suppression (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                pixel_valid,
  output logic                                     pixel_stall,
  input  wire fps_pkg::pixel_t                     pixel,
  output logic                                     peak_valid,
  input  wire logic                                peak_stall,
  output fps_pkg::peak_t                           peak,
  input  wire logic                                cfg_we,
  input  wire logic [fps_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  wire logic [fps_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  logic [fps_pkg::BRIGHT_BITS-1:0] peak_threshold;
  logic [fps_pkg::COORD_BITS-1:0]  window_x;
  logic [fps_pkg::COORD_BITS-1:0]  window_y;

  fps_pkg::cmd_t       cmd;
  fps_pkg::dp_status_t status;
  fps_pkg::entry_t     best;
  logic [fps_pkg::FRAME_BITS-1:0] current_frame;
  logic                out_xfer;

  // Configuration registers; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      peak_threshold <= fps_pkg::THRESHOLD_RESET;
      window_x       <= fps_pkg::WINDOW_RESET;
      window_y       <= fps_pkg::WINDOW_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fps_pkg::CFG_THRESHOLD: peak_threshold <= cfg_data[fps_pkg::BRIGHT_BITS-1:0];
        fps_pkg::CFG_WINDOW_X:  window_x       <= cfg_data[fps_pkg::COORD_BITS-1:0];
        fps_pkg::CFG_WINDOW_Y:  window_y       <= cfg_data[fps_pkg::COORD_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: load, scan passes, decide, emit
  fps_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_eof   (pixel.end_of_frame),
    .status      (status),
    .out_xfer    (out_xfer),
    .pixel_stall (pixel_stall),
    .cmd         (cmd)
  );

  // Store, scan pipeline, suppression and running maximum
  fps_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .pixel         (pixel),
    .threshold     (peak_threshold),
    .window_x      (window_x),
    .window_y      (window_y),
    .status        (status),
    .best          (best),
    .current_frame (current_frame)
  );

  // Peaks are held until the search ends, since the last and truncated flags
  // are only known then; they then leave through a registered output stage.
  fps_outbuf u_outbuf (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .best          (best),
    .current_frame (current_frame),
    .peak_stall    (peak_stall),
    .peak_valid    (peak_valid),
    .peak          (peak),
    .out_xfer      (out_xfer)
  );

endmodule

`default_nettype wire

@@ rtl/core/fps_datapath.sv @@
// Datapath: pixel store, scan pipeline with suppression and running maximum.
`default_nettype none

module fps_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire fps_pkg::cmd_t                     cmd,
  input  wire fps_pkg::pixel_t                   pixel,
  input  wire logic [fps_pkg::BRIGHT_BITS-1:0]   threshold,
  input  wire logic [fps_pkg::COORD_BITS-1:0]    window_x,
  input  wire logic [fps_pkg::COORD_BITS-1:0]    window_y,
  output fps_pkg::dp_status_t                    status,
  output fps_pkg::entry_t                        best,
  output logic [fps_pkg::FRAME_BITS-1:0]         current_frame
);

  fps_pkg::entry_t pixel_store [fps_pkg::MAX_PIXELS];

  logic [fps_pkg::PIX_CW-1:0]     pixel_count;
  logic                           overflow;
  logic                           store_full;

  logic                           rd_active;
  logic [fps_pkg::PIX_AW-1:0]     rd_addr;
  logic                           rd_is_last;
  fps_pkg::entry_t                rd_entry;

  logic                           proc_valid;
  logic                           proc_last;
  logic [fps_pkg::PIX_AW-1:0]     proc_addr;

  logic                           sup_en;
  logic [fps_pkg::COORD_BITS-1:0] center_x;
  logic [fps_pkg::COORD_BITS-1:0] center_y;
  logic [fps_pkg::COORD_BITS-1:0] dx;
  logic [fps_pkg::COORD_BITS-1:0] dy;
  logic                           sup_hit;
  logic [fps_pkg::BRIGHT_BITS-1:0] eff_bright;
  fps_pkg::entry_t                load_entry;

  assign store_full = (pixel_count >= fps_pkg::PIX_CW'(fps_pkg::MAX_PIXELS));
  assign rd_is_last = (fps_pkg::PIX_CW'(rd_addr) + 1'b1) == pixel_count;

  assign load_entry.x      = pixel.pixel_x;
  assign load_entry.y      = pixel.pixel_y;
  assign load_entry.bright = pixel.pixel_brightness;

  assign dx = (rd_entry.x >= center_x) ? rd_entry.x - center_x : center_x - rd_entry.x;
  assign dy = (rd_entry.y >= center_y) ? rd_entry.y - center_y : center_y - rd_entry.y;
  assign sup_hit    = sup_en && (dx <= window_x) && (dy <= window_y);
  assign eff_bright = sup_hit ? '0 : rd_entry.bright;

  // Store: one write port (load or suppression), one registered read port
  always_ff @(posedge clk) begin
    if (cmd.load && !store_full) begin
      pixel_store[pixel_count[fps_pkg::PIX_AW-1:0]] <= load_entry;
    end else if (proc_valid && sup_hit) begin
      pixel_store[proc_addr] <= '{x: rd_entry.x, y: rd_entry.y, bright: '0};
    end
    if (rd_active) begin
      rd_entry <= pixel_store[rd_addr];
    end
  end

  // Frame bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count   <= '0;
      overflow      <= 1'b0;
      current_frame <= '0;
    end else if (cmd.clear_frame) begin
      pixel_count <= '0;
      overflow    <= 1'b0;
    end else if (cmd.load) begin
      if (pixel_count == '0) begin
        current_frame <= pixel.frame_number;
      end
      if (store_full) begin
        overflow <= 1'b1;
      end else begin
        pixel_count <= pixel_count + 1'b1;
      end
    end
  end

  // Read sequencing and pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_active  <= 1'b0;
      rd_addr    <= '0;
      proc_valid <= 1'b0;
      proc_last  <= 1'b0;
      proc_addr  <= '0;
    end else begin
      proc_valid <= rd_active;
      proc_last  <= rd_active && rd_is_last;
      proc_addr  <= rd_addr;
      if (cmd.pass_start) begin
        rd_active <= 1'b1;
        rd_addr   <= '0;
      end else if (rd_active) begin
        if (rd_is_last) begin
          rd_active <= 1'b0;
        end else begin
          rd_addr <= rd_addr + 1'b1;
        end
      end
    end
  end

  // Running maximum; later pixel wins a tie
  always_ff @(posedge clk) begin
    if (rst) begin
      sup_en <= 1'b0;
    end else if (cmd.pass_start) begin
      sup_en <= cmd.suppress;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pass_start) begin
      center_x    <= best.x;
      center_y    <= best.y;
      best.bright <= '0;
    end else if (proc_valid && (eff_bright >= best.bright)) begin
      best <= '{x: rd_entry.x, y: rd_entry.y, bright: eff_bright};
    end
  end

  assign status.pass_done = proc_valid && proc_last;
  assign status.qualify   = (best.bright != '0) && (best.bright >= threshold);
  assign status.overflow  = overflow;

endmodule

`default_nettype wire

@@ rtl/core/fps_outbuf.sv @@
// Peak buffer and output register for the result channel.
`default_nettype none

module fps_outbuf (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire fps_pkg::cmd_t                   cmd,
  input  wire fps_pkg::entry_t                 best,
  input  wire logic [fps_pkg::FRAME_BITS-1:0]  current_frame,
  input  wire logic                            peak_stall,
  output logic                                 peak_valid,
  output fps_pkg::peak_t                       peak,
  output logic                                 out_xfer
);

  fps_pkg::entry_t peak_mem [fps_pkg::MAX_PEAKS];
  fps_pkg::entry_t rd_entry;

  assign out_xfer = peak_valid && !peak_stall;

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      peak_mem[cmd.buf_idx] <= best;
    end
    if (cmd.buf_rd) begin
      rd_entry <= peak_mem[cmd.buf_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      peak <= '{peak_frame:      current_frame,
                peak_x:          rd_entry.x,
                peak_y:          rd_entry.y,
                peak_brightness: rd_entry.bright,
                last_peak:       cmd.last,
                frame_truncated: cmd.truncated};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_valid <= 1'b0;
    end else if (cmd.out_load) begin
      peak_valid <= 1'b1;
    end else if (out_xfer) begin
      peak_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/fps_ctrl.sv @@
// Controller: frame load, greedy search passes and peak emission sequencing.
`default_nettype none

module fps_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 pixel_valid,
  input  wire logic                 pixel_eof,
  input  wire fps_pkg::dp_status_t  status,
  input  wire logic                 out_xfer,
  output logic                      pixel_stall,
  output fps_pkg::cmd_t             cmd
);

  typedef enum logic [5:0] {
    S_LOAD      = 6'b000001,
    S_SCAN      = 6'b000010,
    S_DECIDE    = 6'b000100,
    S_EMIT_RD   = 6'b001000,
    S_EMIT_LD   = 6'b010000,
    S_EMIT_WAIT = 6'b100000
  } state_t;

  state_t                      state;
  state_t                      state_next;
  logic [fps_pkg::PEAK_CW-1:0] peak_cnt;
  logic [fps_pkg::PEAK_CW-1:0] emit_idx;
  logic                        peak_trunc;
  logic                        accept;
  logic                        room;
  logic                        emit_last;

  assign accept    = pixel_valid && (state == S_LOAD);
  assign room      = peak_cnt < fps_pkg::PEAK_CW'(fps_pkg::MAX_PEAKS);
  assign emit_last = (emit_idx + 1'b1) == peak_cnt;

  assign pixel_stall = (state != S_LOAD);

  always_comb begin
    state_next      = state;
    cmd             = '0;
    cmd.load        = accept;
    cmd.buf_idx     = emit_idx[fps_pkg::PEAK_AW-1:0];
    cmd.last        = emit_last;
    cmd.truncated   = peak_trunc || status.overflow;
    unique case (state)
      S_LOAD: begin
        if (accept && pixel_eof) begin
          cmd.pass_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (status.pass_done) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.buf_idx = peak_cnt[fps_pkg::PEAK_AW-1:0];
        if (status.qualify && room) begin
          cmd.push       = 1'b1;
          cmd.pass_start = 1'b1;
          cmd.suppress   = 1'b1;
          state_next     = S_SCAN;
        end else if (status.qualify || (peak_cnt != '0)) begin
          state_next = S_EMIT_RD;
        end else begin
          cmd.clear_frame = 1'b1;
          state_next      = S_LOAD;
        end
      end
      S_EMIT_RD: begin
        cmd.buf_rd = 1'b1;
        state_next = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        cmd.out_load = 1'b1;
        state_next   = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (out_xfer) begin
          if (emit_last) begin
            cmd.clear_frame = 1'b1;
            state_next      = S_LOAD;
          end else begin
            state_next = S_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      peak_cnt   <= '0;
      emit_idx   <= '0;
      peak_trunc <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && pixel_eof) begin
        peak_cnt   <= '0;
        peak_trunc <= 1'b0;
      end
      if (state == S_DECIDE) begin
        emit_idx <= '0;
        if (status.qualify && room) begin
          peak_cnt <= peak_cnt + 1'b1;
        end else if (status.qualify) begin
          peak_trunc <= 1'b1;
        end
      end
      if ((state == S_EMIT_WAIT) && out_xfer) begin
        emit_idx <= emit_idx + 1'b1;
      end
    end
  end

  a_peak_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    peak_cnt <= fps_pkg::PEAK_CW'(fps_pkg::MAX_PEAKS))
    else $error("peak count exceeds buffer depth");

  a_emit_has_peaks: assert property (@(posedge clk) disable iff (rst)
    (state == S_EMIT_RD || state == S_EMIT_LD || state == S_EMIT_WAIT) |-> (peak_cnt != '0))
    else $error("emission with an empty peak buffer");

  a_pass_done_in_scan: assert property (@(posedge clk) disable iff (rst)
    status.pass_done |-> (state == S_SCAN))
    else $error("scan pass finished outside of a scan");

  a_load_then_clear: assert property (@(posedge clk) disable iff (rst)
    cmd.clear_frame |=> (state == S_LOAD))
    else $error("frame cleared without returning to load");

endmodule

`default_nettype wire

@@ test/fps_checker.sv @@
// Scoreboard for the frame peak suppression block: predicts peaks from observed transfers and checks them.
`timescale 1ns / 1ps

module fps_checker
  import fps_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     pixel_valid,
  input  logic                     pixel_stall,
  input  pixel_t                   pixel,
  input  logic                     peak_valid,
  input  logic                     peak_stall,
  input  peak_t                    peak,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output int                       errors,
  output int                       outstanding,
  output int                       peaks_checked
);

  entry_t                 frame_pixels [MAX_PIXELS];
  int                     n_held;
  logic [FRAME_BITS-1:0]  frame_id;
  logic                   lost_pixel;
  logic [BRIGHT_BITS-1:0] thr;
  logic [COORD_BITS-1:0]  win_x;
  logic [COORD_BITS-1:0]  win_y;
  peak_t                  expected_peaks [$];
  int                     n_errors;
  int                     n_checked;

  function automatic logic [COORD_BITS-1:0] coord_gap(input logic [COORD_BITS-1:0] a,
                                                      input logic [COORD_BITS-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Index of the brightest held pixel, the later one on a tie; -1 when none qualifies.
  function automatic int brightest();
    int                     best;
    logic [BRIGHT_BITS-1:0] best_b;
    best = -1;
    best_b = '0;
    for (int i = 0; i < n_held; i++) begin
      if (frame_pixels[i].bright >= best_b) begin
        best = i;
        best_b = frame_pixels[i].bright;
      end
    end
    if (best < 0 || best_b == '0 || best_b < thr) return -1;
    return best;
  endfunction

  task automatic show_peak(input string tag, input peak_t p);
    $display("  %s frame=%h x=%0d y=%0d brightness=%0d last=%b truncated=%b", tag,
             p.peak_frame, p.peak_x, p.peak_y, p.peak_brightness, p.last_peak,
             p.frame_truncated);
  endtask

  // Hold one pixel; on the frame's last pixel run the greedy search and queue its peaks.
  task automatic absorb_pixel(input pixel_t p);
    peak_t  found [$];
    peak_t  pk;
    entry_t top_px;
    int     idx;
    logic   trunc;
    if (n_held == 0) frame_id = p.frame_number;
    if (n_held < MAX_PIXELS) begin
      frame_pixels[n_held].x = p.pixel_x;
      frame_pixels[n_held].y = p.pixel_y;
      frame_pixels[n_held].bright = p.pixel_brightness;
      n_held++;
    end else begin
      lost_pixel = 1'b1;
    end
    if (p.end_of_frame) begin
      trunc = lost_pixel;
      idx = brightest();
      while (idx >= 0) begin
        if (found.size() >= MAX_PEAKS) begin
          trunc = 1'b1;
          break;
        end
        top_px = frame_pixels[idx];
        pk.peak_frame = frame_id;
        pk.peak_x = top_px.x;
        pk.peak_y = top_px.y;
        pk.peak_brightness = top_px.bright;
        pk.last_peak = 1'b0;
        pk.frame_truncated = 1'b0;
        found = {found, pk};
        for (int i = 0; i < n_held; i++) begin
          if (coord_gap(frame_pixels[i].x, top_px.x) <= win_x &&
              coord_gap(frame_pixels[i].y, top_px.y) <= win_y)
            frame_pixels[i].bright = '0;
        end
        idx = brightest();
      end
      foreach (found[k]) begin
        found[k].frame_truncated = trunc;
        found[k].last_peak = (k == found.size() - 1);
        expected_peaks = {expected_peaks, found[k]};
      end
      n_held = 0;
      lost_pixel = 1'b0;
    end
  endtask

  always @(posedge clk) begin : watch
    peak_t exp_pk;
    if (rst) begin
      n_held = 0;
      frame_id = '0;
      lost_pixel = 1'b0;
      thr = THRESHOLD_RESET;
      win_x = WINDOW_RESET;
      win_y = WINDOW_RESET;
      expected_peaks.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_THRESHOLD: thr = cfg_data[BRIGHT_BITS-1:0];
          CFG_WINDOW_X:  win_x = cfg_data[COORD_BITS-1:0];
          CFG_WINDOW_Y:  win_y = cfg_data[COORD_BITS-1:0];
          default: ;
        endcase
      end
      // Check the output side first so a pixel landing on the same edge cannot jump the queue.
      if (peak_valid && !peak_stall) begin
        n_checked++;
        if (expected_peaks.size() == 0) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("%0t: peak transfer with nothing expected", $time);
            show_peak("got     ", peak);
          end
        end else begin
          exp_pk = expected_peaks.pop_front();
          if (peak.peak_frame !== exp_pk.peak_frame || peak.peak_x !== exp_pk.peak_x ||
              peak.peak_y !== exp_pk.peak_y ||
              peak.peak_brightness !== exp_pk.peak_brightness ||
              peak.last_peak !== exp_pk.last_peak ||
              peak.frame_truncated !== exp_pk.frame_truncated) begin
            n_errors++;
            if (n_errors <= 10) begin
              $display("%0t: peak transfer %0d mismatch", $time, n_checked);
              show_peak("expected", exp_pk);
              show_peak("got     ", peak);
            end
          end
        end
      end
      if (pixel_valid && !pixel_stall) absorb_pixel(pixel);
    end
    errors <= n_errors;
    outstanding <= expected_peaks.size();
    peaks_checked <= n_checked;
  end

endmodule

@@ test/tb.sv @@
// Testbench top for the frame peak suppression block: reset, register settings and pixel stimulus.
`timescale 1ns / 1ps

module tb;
  import fps_pkg::*;

  // Index with no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] CFG_SPARE = 2'd3;
  // A frame with no peak still takes one full scan of the store after its last pixel.
  localparam int DRAIN_CYCLES = 2 * MAX_PIXELS;
  localparam int RANDOM_ITEMS = 90;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     pixel_valid = 1'b0;
  logic                     pixel_stall;
  pixel_t                   pixel = '0;
  logic                     peak_valid;
  logic                     peak_stall = 1'b0;
  peak_t                    peak;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_data = '0;

  int                     errors;
  int                     outstanding;
  int                     peaks_checked;
  logic                   idle_on = 1'b0;
  int                     stall_left = 0;
  logic [BRIGHT_BITS-1:0] cur_thr = THRESHOLD_RESET;
  int                     pixels_sent = 0;
  int                     frames_sent = 0;
  int                     random_items = 0;
  int                     settings_used = 0;

  always #1 clk = ~clk;

  frame_peak_suppression dut (
    .clk         (clk),
    .rst         (rst),
    .pixel_valid (pixel_valid),
    .pixel_stall (pixel_stall),
    .pixel       (pixel),
    .peak_valid  (peak_valid),
    .peak_stall  (peak_stall),
    .peak        (peak),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  fps_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .pixel_valid   (pixel_valid),
    .pixel_stall   (pixel_stall),
    .pixel         (pixel),
    .peak_valid    (peak_valid),
    .peak_stall    (peak_stall),
    .peak          (peak),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .outstanding   (outstanding),
    .peaks_checked (peaks_checked)
  );

  // Output backpressure: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      peak_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      peak_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      peak_stall <= 1'b1;
      stall_left <= $urandom_range(0, 8);
    end else begin
      peak_stall <= 1'b0;
    end
  end

  function automatic pixel_t make_pixel(input logic [FRAME_BITS-1:0] f,
                                        input logic [COORD_BITS-1:0] x,
                                        input logic [COORD_BITS-1:0] y,
                                        input logic [BRIGHT_BITS-1:0] b,
                                        input logic eof);
    pixel_t p;
    p.frame_number = f;
    p.pixel_x = x;
    p.pixel_y = y;
    p.pixel_brightness = b;
    p.end_of_frame = eof;
    return p;
  endfunction

  // Present one pixel, optionally after an idle burst, and hold it until the transfer.
  task automatic send_pixel(input pixel_t p);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      pixel_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel <= p;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    pixels_sent++;
  endtask

  // Drop valid, wait for every predicted peak, then give a no-peak scan time to finish.
  task automatic drain();
    pixel_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  // Write all three registers; the spare write comes last so an alias would show.
  task automatic apply_settings(input logic [BRIGHT_BITS-1:0] t,
                                input logic [COORD_BITS-1:0] wx,
                                input logic [COORD_BITS-1:0] wy,
                                input bit spare);
    write_reg(CFG_THRESHOLD, CFG_DATA_BITS'(t));
    write_reg(CFG_WINDOW_X, CFG_DATA_BITS'(wx));
    write_reg(CFG_WINDOW_Y, CFG_DATA_BITS'(wy));
    if (spare) write_reg(CFG_SPARE, '1);
    cfg_we <= 1'b0;
    cur_thr = t;
    settings_used++;
  endtask

  // Half the time values that decide a pass: zero, full scale, at or next to the threshold, ties.
  function automatic logic [BRIGHT_BITS-1:0] pick_brightness(input logic [BRIGHT_BITS-1:0] prev);
    int t;
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: begin
        t = int'(cur_thr) - 1 + int'($urandom_range(0, 2));
        if (t < 0) t = 0;
        if (t > 65535) t = 65535;
        return t[BRIGHT_BITS-1:0];
      end
      3: return prev;
      default: return BRIGHT_BITS'($urandom);
    endcase
  endfunction

  // One frame with random content; most frames cluster so windows overlap.
  task automatic send_random_frame(input int n_pix);
    logic [FRAME_BITS-1:0]  fnum;
    logic [FRAME_BITS-1:0]  f;
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic [BRIGHT_BITS-1:0] b;
    logic                   clustered;
    fnum = $urandom;
    cx = COORD_BITS'($urandom);
    cy = COORD_BITS'($urandom);
    clustered = ($urandom_range(0, 3) != 0);
    b = '0;
    for (int i = 0; i < n_pix; i++) begin
      if (clustered) begin
        x = cx + COORD_BITS'($urandom_range(0, 15));
        y = cy + COORD_BITS'($urandom_range(0, 15));
      end else begin
        x = COORD_BITS'($urandom);
        y = COORD_BITS'($urandom);
      end
      b = pick_brightness(b);
      // A stray frame number on a later pixel must be ignored.
      f = (i != 0 && $urandom_range(0, 7) == 0) ? FRAME_BITS'($urandom) : fnum;
      send_pixel(make_pixel(f, x, y, b, i == n_pix - 1));
    end
    frames_sent++;
  endtask

  initial begin : stimulus
    int n;
    int phase;
    int phase_items;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    idle_on <= 1'b1;
    settings_used = 1;

    // Directed frames under the reset settings: threshold 100, windows 5.
    // Tie at full scale (later wins), neighbor cleared, one below and one at threshold,
    // a zero pixel, and a changed frame number mid-frame.
    send_pixel(make_pixel(32'hFFFF_FFFF, 9'd0, 9'd0, 16'hFFFF, 1'b0));
    send_pixel(make_pixel(32'h0000_0000, 9'd511, 9'd511, 16'hFFFF, 1'b0));
    send_pixel(make_pixel(32'hFFFF_FFFF, 9'd2, 9'd4, 16'd150, 1'b0));
    send_pixel(make_pixel(32'hFFFF_FFFF, 9'd20, 9'd20, 16'd99, 1'b0));
    send_pixel(make_pixel(32'hFFFF_FFFF, 9'd20, 9'd30, 16'd100, 1'b0));
    send_pixel(make_pixel(32'hFFFF_FFFF, 9'd100, 9'd100, 16'd0, 1'b1));
    // No qualifying pixel: no peak, frame still cleared.
    send_pixel(make_pixel(32'h1234_5678, 9'd7, 9'd7, 16'd50, 1'b1));
    // Equal brightness inside one window: only the later one survives.
    send_pixel(make_pixel(32'h0000_0000, 9'd10, 9'd10, 16'd500, 1'b0));
    send_pixel(make_pixel(32'h0000_0000, 9'd12, 9'd12, 16'd500, 1'b1));
    // Single-pixel frame at a corner.
    send_pixel(make_pixel(32'h8000_0001, 9'd511, 9'd0, 16'hFFFF, 1'b1));
    // Window edge: distance exactly 5 is cleared, 6 survives.
    send_pixel(make_pixel(32'h0F0F_F0F0, 9'd50, 9'd50, 16'd300, 1'b0));
    send_pixel(make_pixel(32'h0F0F_F0F0, 9'd55, 9'd45, 16'd200, 1'b0));
    send_pixel(make_pixel(32'h0F0F_F0F0, 9'd56, 9'd50, 16'd250, 1'b1));
    frames_sent += 5;
    drain();

    // Capacity: zero windows and threshold 1 so every distinct pixel is a candidate.
    apply_settings(16'd1, 9'd0, 9'd0, 1'b0);
    // One candidate more than the peak limit: the last one is cut and flags truncation.
    for (int i = 0; i < MAX_PEAKS + 1; i++)
      send_pixel(make_pixel(32'h0000_5A5A, 9'(i * 7), 9'(i * 3), 16'(1000 + i),
                            i == MAX_PEAKS));
    frames_sent += 1;
    drain();

    // Random frames over several settings, extremes first; no idling near the end.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      case (phase)
        0: apply_settings(16'd0, 9'd0, 9'd511, 1'b1);
        1: apply_settings(16'd1, 9'd511, 9'd0, 1'b0);
        2: apply_settings(16'hFFFF, 9'd3, 9'd7, 1'b0);
        default: apply_settings(BRIGHT_BITS'($urandom_range(1, 3000)),
                                COORD_BITS'($urandom_range(0, 20)),
                                COORD_BITS'($urandom_range(0, 20)), 1'b0);
      endcase
      phase_items = 0;
      while (phase_items < 30 && random_items < RANDOM_ITEMS) begin
        idle_on <= (random_items < RANDOM_ITEMS - 30);
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
        send_random_frame(n);
        phase_items += n;
        random_items += n;
      end
      drain();
      phase++;
    end

    $display("Run covered %0d pixel transfers in %0d frames under %0d register settings,",
             pixels_sent, frames_sent, settings_used);
    $display("including a frame past the peak limit; %0d peaks checked.",
             peaks_checked);
    if (outstanding != 0) $display("%0d expected peaks never arrived", outstanding);
    if (errors == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/fps_pkg.sv
rtl/core/fps_datapath.sv
rtl/core/fps_outbuf.sv
rtl/core/fps_ctrl.sv
rtl/core/frame_peak_suppression.sv
test/fps_checker.sv
test/tb.sv
